// ===== sv/bis_pkg.sv =====
// shared types, widths and defaults for the bilinear image scaler
// no dependencies; imported by every module of the block except the frame store
package bis_pkg;

  // default geometry of the frame store
  localparam int unsigned MaxWidthDef      = 1024;
  localparam int unsigned MaxHeightDef     = 1024;
  localparam int unsigned PixelChannelsDef = 3;

  // fixed field widths
  localparam int unsigned PixW    = 8;
  localparam int unsigned NumOutCh = 3;
  localparam int unsigned SrcW    = 10;
  localparam int unsigned DstW    = 12;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned StepW   = 26;
  localparam int unsigned FracW   = 16;
  localparam int unsigned PosW    = DstW + StepW;
  localparam int unsigned IntW    = PosW - FracW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = StepW;

  // blend arithmetic widths
  localparam int unsigned WxW  = FracW + 1;   // one axis weight, up to 1.0
  localparam int unsigned WtW  = 2*FracW + 1; // corner weight, up to 1.0 in Q.32
  localparam int unsigned AccW = 40;          // 255 * 2^32 fits
  localparam int unsigned RndW = AccW + 1;

  localparam logic [WxW-1:0]  OneQ16   = WxW'(1) << FracW;
  localparam logic [RndW-1:0] RoundAdd = RndW'(1) << (2*FracW - 1);

  // configuration register reset values
  localparam logic [SizeW-1:0] SrcWidthRst  = SizeW'(1024);
  localparam logic [SizeW-1:0] SrcHeightRst = SizeW'(1024);
  localparam logic [StepW-1:0] StepRst      = StepW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_H_STEP     = 2'd2,
    CFG_V_STEP     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOC_X,
    S_LOC_Y,
    S_FETCH,
    S_DRAIN,
    S_DONE
  } state_e;

  // sequencer to blend unit
  typedef struct packed {
    logic clear;
    logic weight_en;
  } blend_ctl_t;

endpackage

// ===== sv/bis_locate.sv =====
// axis locator: maps a destination index to floor/ceiling source index and fraction
// depends on bis_pkg; shared between the horizontal and vertical axis
module bis_locate #(
  parameter int unsigned IDX_W = 10
) (
  input  logic [bis_pkg::DstW-1:0]  dst_i,
  input  logic [bis_pkg::StepW-1:0] step_i,
  input  logic [bis_pkg::SizeW-1:0] size_i,
  input  logic [IDX_W:0]            lim_i,
  output logic [IDX_W-1:0]          lo_o,
  output logic [IDX_W-1:0]          hi_o,
  output logic [bis_pkg::FracW-1:0] frac_o
);
  import bis_pkg::*;

  localparam int unsigned CmpW = (SizeW > IDX_W + 1) ? SizeW : IDX_W + 1;

  logic [PosW-1:0] pos;
  logic [IntW-1:0] ip;
  logic [CmpW-1:0] size_ext;
  logic [CmpW-1:0] lim_ext;
  logic [CmpW-1:0] size_eff;
  logic [IDX_W-1:0] last;
  logic [IntW-1:0]  last_ext;
  logic [IDX_W-1:0] lo;

  assign pos    = PosW'(dst_i) * PosW'(step_i);
  assign ip     = pos[PosW-1:FracW];
  assign frac_o = pos[FracW-1:0];

  // zero size acts as one, oversize acts as the store limit
  assign size_ext = CmpW'(size_i);
  assign lim_ext  = CmpW'(lim_i);
  always_comb begin
    if (size_ext == '0) begin
      size_eff = CmpW'(1);
    end else if (size_ext > lim_ext) begin
      size_eff = lim_ext;
    end else begin
      size_eff = size_ext;
    end
  end

  assign last     = IDX_W'(size_eff - CmpW'(1));
  assign last_ext = IntW'(last);

  assign lo   = (ip > last_ext) ? last : IDX_W'(ip);
  assign lo_o = lo;

  always_comb begin
    if (frac_o == '0) begin
      hi_o = lo;
    end else if (ip >= last_ext) begin
      hi_o = last;
    end else begin
      hi_o = IDX_W'(ip + IntW'(1));
    end
  end

endmodule

// ===== sv/bis_frame_mem.sv =====
// frame store: one write port, one read port with registered read data
// depends on nothing but its parameters
module bis_frame_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bis_blend.sv =====
// blend unit: corner weight multiplier and per-channel multiply-accumulate
// depends on bis_pkg; fed one corner pixel per cycle by the sequencer
module bis_blend #(
  parameter int unsigned PIXEL_CHANNELS = bis_pkg::PixelChannelsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  bis_pkg::blend_ctl_t                          ctl_i,
  input  logic [bis_pkg::FracW-1:0]                    fx_i,
  input  logic [bis_pkg::FracW-1:0]                    fy_i,
  input  logic [1:0]                                   corner_i,
  input  logic [bis_pkg::PixW*PIXEL_CHANNELS-1:0]      pix_i,
  output logic [bis_pkg::NumOutCh-1:0][bis_pkg::PixW-1:0] rgb_o
);
  import bis_pkg::*;

  logic [WxW-1:0]   wx;
  logic [WxW-1:0]   wy;
  logic [2*WxW-1:0] wxy;
  logic [WtW-1:0]   wt_q;
  logic             acc_en_q;
  logic [AccW-1:0]  acc_q [PIXEL_CHANNELS];

  // corner bit 0 picks the ceiling column, bit 1 the ceiling row
  assign wx  = corner_i[0] ? WxW'(fx_i) : OneQ16 - WxW'(fx_i);
  assign wy  = corner_i[1] ? WxW'(fy_i) : OneQ16 - WxW'(fy_i);
  assign wxy = (2*WxW)'(wx) * (2*WxW)'(wy);

  always_ff @(posedge clk_i) begin
    if (ctl_i.weight_en) begin
      wt_q <= wxy[WtW-1:0];
    end
  end

  // weight and read data are registered with the request and land together in the cycle after it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= ctl_i.weight_en;
    end
  end

  for (genvar c = 0; c < PIXEL_CHANNELS; c++) begin : g_lane
    logic [PixW+WtW-1:0] prod;
    assign prod = (PixW+WtW)'(pix_i[c*PixW +: PixW]) * (PixW+WtW)'(wt_q);

    always_ff @(posedge clk_i) begin
      if (ctl_i.clear) begin
        acc_q[c] <= '0;
      end else if (acc_en_q) begin
        acc_q[c] <= acc_q[c] + AccW'(prod);
      end
    end
  end

  for (genvar c = 0; c < NumOutCh; c++) begin : g_out
    if (c < PIXEL_CHANNELS) begin : g_used
      logic [RndW-1:0] rnd;
      assign rnd      = RndW'(acc_q[c]) + RoundAdd;
      assign rgb_o[c] = rnd[AccW-1 -: PixW];
    end else begin : g_unused
      assign rgb_o[c] = '0;
    end
  end

endmodule

// ===== sv/bilinear_image_scaler.sv =====
// bilinear image scaler top level: frame store, sequencer, locator and blend unit
// depends on bis_pkg, bis_locate, bis_frame_mem and bis_blend
//
// channel   direction  handshake                   payload
// in        sink       in_valid_i / in_ready_o      opcode, src_col/row, rgb, dst_col/row
// out       source     out_valid_o / out_ready_i    out_red, out_green, out_blue
// cfg       sink       cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// a write request goes straight into the frame store
// a read request passes through these sequencer states before its result is valid:
//   S_LOC_X and S_LOC_Y to locate on the shared axis multiplier, S_FETCH for the four
//   frame store reads on the single read port, S_DRAIN for the last accumulate and
//   S_DONE to round, so a new read request is taken only after the last one leaves S_DONE
// in_ready_o is high only between read requests; the result sits in an output
//   register, so the next request is taken while a result waits on out_ready_i
// frame store content is undefined after reset and needs no clearing pass
module bilinear_image_scaler #(
  parameter int unsigned MAX_WIDTH      = bis_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT     = bis_pkg::MaxHeightDef,
  parameter int unsigned PIXEL_CHANNELS = bis_pkg::PixelChannelsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [bis_pkg::SrcW-1:0]    src_col_i,
  input  logic [bis_pkg::SrcW-1:0]    src_row_i,
  input  logic [bis_pkg::PixW-1:0]    in_red_i,
  input  logic [bis_pkg::PixW-1:0]    in_green_i,
  input  logic [bis_pkg::PixW-1:0]    in_blue_i,
  input  logic [bis_pkg::DstW-1:0]    dst_col_i,
  input  logic [bis_pkg::DstW-1:0]    dst_row_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bis_pkg::PixW-1:0]    out_red_o,
  output logic [bis_pkg::PixW-1:0]    out_green_o,
  output logic [bis_pkg::PixW-1:0]    out_blue_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bis_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bis_pkg::CfgW-1:0]    cfg_data_i
);
  import bis_pkg::*;

  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned IW     = $clog2(MaxDim);
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned DW     = PixW * PIXEL_CHANNELS;

  // configuration registers
  logic [SizeW-1:0] source_width_q;
  logic [SizeW-1:0] source_height_q;
  logic [StepW-1:0] horizontal_step_q;
  logic [StepW-1:0] vertical_step_q;

  // sequencer
  state_e     state_q, state_d;
  logic [1:0] corner_q, corner_d;
  blend_ctl_t blend_ctl;
  logic       loc_y;
  logic       rd_en;
  logic       out_load;

  // request capture and located neighbours
  logic [DstW-1:0]  dst_col_q, dst_row_q;
  logic [IW-1:0]    x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic [FracW-1:0] fx_q, fy_q;

  // locator hookup, muxed between the two axes
  logic [DstW-1:0]  loc_dst;
  logic [StepW-1:0] loc_step;
  logic [SizeW-1:0] loc_size;
  logic [IW:0]      loc_lim;
  logic [IW-1:0]    loc_lo, loc_hi;
  logic [FracW-1:0] loc_frac;

  // frame store hookup
  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic [IW-1:0] rd_col;
  logic [IW-1:0] rd_row;

  // output register
  logic                          out_valid_q;
  logic [NumOutCh-1:0][PixW-1:0] rgb;
  logic [NumOutCh-1:0][PixW-1:0] rgb_q;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_width_q    <= SrcWidthRst;
      source_height_q   <= SrcHeightRst;
      horizontal_step_q <= StepRst;
      vertical_step_q   <= StepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:  source_width_q    <= cfg_data_i[SizeW-1:0];
        CFG_SRC_HEIGHT: source_height_q   <= cfg_data_i[SizeW-1:0];
        CFG_H_STEP:     horizontal_step_q <= cfg_data_i[StepW-1:0];
        CFG_V_STEP:     vertical_step_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    corner_d  = corner_q;
    blend_ctl = '0;
    loc_y     = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (opcode_i == OP_READ)) begin
          blend_ctl.clear = 1'b1;
          state_d         = S_LOC_X;
        end
      end
      S_LOC_X: begin
        state_d = S_LOC_Y;
      end
      S_LOC_Y: begin
        loc_y    = 1'b1;
        corner_d = '0;
        state_d  = S_FETCH;
      end
      S_FETCH: begin
        // one corner per cycle through the single read port
        rd_en               = 1'b1;
        blend_ctl.weight_en = 1'b1;
        corner_d            = corner_q + 2'd1;
        if (&corner_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold the sum until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // capture destination coordinates with the read request
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == OP_READ)) begin
      dst_col_q <= dst_col_i;
      dst_row_q <= dst_row_i;
    end
  end

  // shared locator: x axis in S_LOC_X, then y axis in S_LOC_Y
  assign loc_dst  = loc_y ? dst_row_q : dst_col_q;
  assign loc_step = loc_y ? vertical_step_q : horizontal_step_q;
  assign loc_size = loc_y ? source_height_q : source_width_q;
  assign loc_lim  = loc_y ? (IW+1)'(MAX_HEIGHT) : (IW+1)'(MAX_WIDTH);

  bis_locate #(
    .IDX_W (IW)
  ) u_locate (
    .dst_i  (loc_dst),
    .step_i (loc_step),
    .size_i (loc_size),
    .lim_i  (loc_lim),
    .lo_o   (loc_lo),
    .hi_o   (loc_hi),
    .frac_o (loc_frac)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOC_X) begin
      x_lo_q <= loc_lo;
      x_hi_q <= loc_hi;
      fx_q   <= loc_frac;
    end
    if (state_q == S_LOC_Y) begin
      y_lo_q <= loc_lo;
      y_hi_q <= loc_hi;
      fy_q   <= loc_frac;
    end
  end

  // write requests outside the store are dropped
  assign wr_en = in_acc && (opcode_i == OP_WRITE)
                 && (int'(src_col_i) < MAX_WIDTH) && (int'(src_row_i) < MAX_HEIGHT);
  assign waddr = AW'(RW'(src_row_i)) * AW'(MAX_WIDTH) + AW'(CW'(src_col_i));
  assign wdata = DW'({in_blue_i, in_green_i, in_red_i});

  // corner bit 0 selects ceiling column, bit 1 ceiling row
  assign rd_col = corner_q[0] ? x_hi_q : x_lo_q;
  assign rd_row = corner_q[1] ? y_hi_q : y_lo_q;
  assign raddr  = AW'(RW'(rd_row)) * AW'(MAX_WIDTH) + AW'(CW'(rd_col));

  bis_frame_mem #(
    .DEPTH (Depth),
    .AW    (AW),
    .DW    (DW)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bis_blend #(
    .PIXEL_CHANNELS (PIXEL_CHANNELS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (blend_ctl),
    .fx_i     (fx_q),
    .fy_i     (fy_q),
    .corner_i (corner_q),
    .pix_i    (rdata),
    .rgb_o    (rgb)
  );

  // output register parts the result from the next request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rgb_q <= rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = rgb_q[0];
  assign out_green_o = rgb_q[1];
  assign out_blue_o  = rgb_q[2];

`ifndef ASSERT_OFF
  // an accepted read request always starts the locate phase
  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == OP_READ)) |=> (state_q == S_LOC_X))
    else $error("read request did not start locate phase");

  // a write request never makes a result appear
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == OP_WRITE) && !out_valid_o) |=> !out_valid_o)
    else $error("write request produced a result");

  // a result only appears after the rounding cycle
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_DONE))
    else $error("result appeared outside the done state");

  // memory reads only happen while fetching corners
  a_fetch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> ((state_q == S_FETCH) && !in_ready_o))
    else $error("frame store read outside fetch phase");
`endif

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the bilinear image scaler: predicts every destination pixel
// from a shadow frame store and compares each result field by field
// depends on bis_pkg and the bilinear_image_scaler rtl
`timescale 1ns / 1ps

module testbench;
  import bis_pkg::*;

  // sizing of the run
  localparam int unsigned RandomItems = 1100;  // random requests after the directed part
  localparam int unsigned FrameReqs   = 60;    // mixed requests per random frame
  localparam int unsigned DrainCycles = 12;    // block latency plus margin
  localparam int unsigned HoldCycles  = 200;   // long receiver stall for the pressure test
  localparam int unsigned MaxGap      = 30;

  // one request on the input channel
  typedef struct {
    opcode_e          op;
    logic [SrcW-1:0]  src_col;
    logic [SrcW-1:0]  src_row;
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  blue;
    logic [DstW-1:0]  dst_col;
    logic [DstW-1:0]  dst_row;
  } pixel_req_t;

  // one interpolated destination pixel
  typedef struct {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } rgb_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel drive
  logic            req_valid = 1'b0;
  opcode_e         req_op    = OP_WRITE;
  logic [SrcW-1:0] req_src_col = '0;
  logic [SrcW-1:0] req_src_row = '0;
  logic [PixW-1:0] req_red   = '0;
  logic [PixW-1:0] req_green = '0;
  logic [PixW-1:0] req_blue  = '0;
  logic [DstW-1:0] req_dst_col = '0;
  logic [DstW-1:0] req_dst_row = '0;
  logic            in_ready_o;

  // result channel
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  logic [PixW-1:0] out_red_o;
  logic [PixW-1:0] out_green_o;
  logic [PixW-1:0] out_blue_o;

  // configuration channel drive
  logic            cfg_valid = 1'b0;
  cfg_idx_e        cfg_index = CFG_SRC_WIDTH;
  logic [CfgW-1:0] cfg_data  = '0;
  logic            cfg_ready_o;

  // shadow of the configuration registers, reset values first
  logic [SizeW-1:0] cfg_width  = SrcWidthRst;
  logic [SizeW-1:0] cfg_height = SrcHeightRst;
  logic [StepW-1:0] cfg_hstep  = StepRst;
  logic [StepW-1:0] cfg_vstep  = StepRst;

  // shadow frame store: only written entries exist, packed {blue, green, red}
  logic [3*PixW-1:0] pixel_mem [int unsigned];
  // destination pixels still owed by the block, oldest first
  rgb_t              pixel_q [$];

  // idling and pressure controls
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_start    = 1'b0;
  int unsigned hold_left     = 0;

  // bookkeeping
  int unsigned writes_sent  = 0;
  int unsigned reads_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned frames_run   = 0;
  int unsigned fail_cnt     = 0;

  bilinear_image_scaler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (in_ready_o),
    .opcode_i    (req_op),
    .src_col_i   (req_src_col),
    .src_row_i   (req_src_row),
    .in_red_i    (req_red),
    .in_green_i  (req_green),
    .in_blue_i   (req_blue),
    .dst_col_i   (req_dst_col),
    .dst_row_i   (req_dst_row),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // size register as the block uses it: zero acts as one, large values saturate
  function automatic int unsigned eff_size(logic [SizeW-1:0] raw, int unsigned max_size);
    if (raw == '0) return 1;
    return (raw > max_size) ? max_size : int'(raw);
  endfunction

  function automatic int unsigned mem_key(int unsigned col, int unsigned row);
    return row * MaxWidthDef + col;
  endfunction

  // floor and ceiling neighbour plus fraction along one axis
  function automatic void locate_axis(input logic [DstW-1:0] dst, input logic [StepW-1:0] step,
                                      input int unsigned size, output int unsigned lo,
                                      output int unsigned hi, output logic [FracW-1:0] frac);
    logic [PosW-1:0] pos;
    int unsigned     ip;
    pos  = PosW'(dst) * PosW'(step);
    ip   = int'(pos >> FracW);
    frac = pos[FracW-1:0];
    // floor past the edge repeats the edge pixel
    lo = (ip > size - 1) ? size - 1 : ip;
    // zero fraction needs no second neighbour; the ceiling clamps to the edge
    if (frac == '0) hi = lo;
    else            hi = (ip + 1 > size - 1) ? size - 1 : ip + 1;
  endfunction

  // every store entry a read request would touch has been written
  function automatic bit read_is_safe(logic [DstW-1:0] dc, logic [DstW-1:0] dr);
    int unsigned      x0, x1, y0, y1;
    logic [FracW-1:0] fx, fy;
    locate_axis(dc, cfg_hstep, eff_size(cfg_width, MaxWidthDef), x0, x1, fx);
    locate_axis(dr, cfg_vstep, eff_size(cfg_height, MaxHeightDef), y0, y1, fy);
    return pixel_mem.exists(mem_key(x0, y0)) && pixel_mem.exists(mem_key(x1, y0)) &&
           pixel_mem.exists(mem_key(x0, y1)) && pixel_mem.exists(mem_key(x1, y1));
  endfunction

  // horizontal blend on both rows, then vertical, rounded once at the end
  function automatic rgb_t interpolate(logic [DstW-1:0] dc, logic [DstW-1:0] dr);
    int unsigned       x0, x1, y0, y1;
    logic [FracW-1:0]  fx, fy;
    logic [3*PixW-1:0] p00, p01, p10, p11;
    logic [63:0]       wx0, wx1, wy0, wy1, top, bot, acc;
    logic [PixW-1:0]   chan [NumOutCh];
    rgb_t              res;
    locate_axis(dc, cfg_hstep, eff_size(cfg_width, MaxWidthDef), x0, x1, fx);
    locate_axis(dr, cfg_vstep, eff_size(cfg_height, MaxHeightDef), y0, y1, fy);
    p00 = pixel_mem[mem_key(x0, y0)];
    p01 = pixel_mem[mem_key(x1, y0)];
    p10 = pixel_mem[mem_key(x0, y1)];
    p11 = pixel_mem[mem_key(x1, y1)];
    wx1 = 64'(fx);
    wx0 = 64'(OneQ16) - wx1;
    wy1 = 64'(fy);
    wy0 = 64'(OneQ16) - wy1;
    for (int c = 0; c < NumOutCh; c++) begin
      top = 64'(p00[PixW*c +: PixW]) * wx0 + 64'(p01[PixW*c +: PixW]) * wx1;
      bot = 64'(p10[PixW*c +: PixW]) * wx0 + 64'(p11[PixW*c +: PixW]) * wx1;
      acc = top * wy0 + bot * wy1;
      // round half up in Q.32
      chan[c] = PixW'((acc + 64'(RoundAdd)) >> (2*FracW));
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // fields a request does not use still carry random bits
  function automatic pixel_req_t write_req(int unsigned col, int unsigned row,
                                           logic [PixW-1:0] red, logic [PixW-1:0] green,
                                           logic [PixW-1:0] blue);
    pixel_req_t r;
    r.op      = OP_WRITE;
    r.src_col = SrcW'(col);
    r.src_row = SrcW'(row);
    r.red     = red;
    r.green   = green;
    r.blue    = blue;
    r.dst_col = DstW'($urandom);
    r.dst_row = DstW'($urandom);
    return r;
  endfunction

  function automatic pixel_req_t read_req(int unsigned col, int unsigned row);
    pixel_req_t r;
    r.op      = OP_READ;
    r.src_col = SrcW'($urandom);
    r.src_row = SrcW'($urandom);
    r.red     = PixW'($urandom);
    r.green   = PixW'($urandom);
    r.blue    = PixW'($urandom);
    r.dst_col = DstW'(col);
    r.dst_row = DstW'(row);
    return r;
  endfunction

  // offer one request, wait for its acceptance, then update the predictor
  // valid stays high across back-to-back requests; only a gap or settle() lowers it
  task automatic send_item(pixel_req_t r);
    int unsigned gap;
    // never read a store entry that was not written
    if (r.op == OP_READ && !read_is_safe(r.dst_col, r.dst_row)) return;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid   <= 1'b1;
    req_op      <= r.op;
    req_src_col <= r.src_col;
    req_src_row <= r.src_row;
    req_red     <= r.red;
    req_green   <= r.green;
    req_blue    <= r.blue;
    req_dst_col <= r.dst_col;
    req_dst_row <= r.dst_row;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.op == OP_WRITE) begin
      pixel_mem[mem_key(r.src_col, r.src_row)] = {r.blue, r.green, r.red};
      writes_sent++;
    end else begin
      pixel_q.push_back(interpolate(r.dst_col, r.dst_row));
      reads_sent++;
    end
  endtask

  // drop valid, let every owed result arrive, then let a trailing write finish
  task automatic settle();
    req_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  cfg_width  = val[SizeW-1:0];
      CFG_SRC_HEIGHT: cfg_height = val[SizeW-1:0];
      CFG_H_STEP:     cfg_hstep  = val[StepW-1:0];
      CFG_V_STEP:     cfg_vstep  = val[StepW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // settles first, so the registers are written with the block idle
  task automatic set_geometry(int unsigned raw_w, int unsigned raw_h,
                              logic [StepW-1:0] hstep, logic [StepW-1:0] vstep);
    settle();
    write_reg(CFG_SRC_WIDTH, CfgW'(raw_w));
    write_reg(CFG_SRC_HEIGHT, CfgW'(raw_h));
    write_reg(CFG_H_STEP, CfgW'(hstep));
    write_reg(CFG_V_STEP, CfgW'(vstep));
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // write every pixel of the source area in use, row by row
  task automatic fill_region(int unsigned w, int unsigned h);
    for (int unsigned row = 0; row < h; row++)
      for (int unsigned col = 0; col < w; col++)
        send_item(write_req(col, row, PixW'($urandom), PixW'($urandom), PixW'($urandom)));
  endtask

  function automatic logic [StepW-1:0] pick_step();
    case ($urandom_range(9))
      0, 1, 2, 3: return StepW'($urandom_range(1, 4 << FracW));    // near unity
      4, 5:       return StepW'($urandom_range(1, (1 << StepW) - 1));
      6, 7:       return StepW'($urandom_range(1, 8) << FracW);    // whole steps
      8:          return StepW'($urandom_range(1, (1 << FracW) - 1));
      default:    return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and receiver pacing
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (pixel_q.size() == 0) begin
        $error("result with nothing expected: red %0d green %0d blue %0d",
               out_red_o, out_green_o, out_blue_o);
        fail_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (out_red_o !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_red_o);
          fail_cnt++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_green_o);
          fail_cnt++;
        end
        if (out_blue_o !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_blue_o);
          fail_cnt++;
        end
      end
    end
    // a long hold is counted here, random stalls otherwise
    if (hold_start) hold_left = HoldCycles;
    else if (hold_left != 0) hold_left--;
    out_ready <= !hold_start && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry: unit steps, so each destination pixel is one source pixel
  task automatic test_reset_geometry();
    send_item(write_req(0, 0, 8'hff, 8'h00, 8'haa));
    send_item(write_req(1023, 1023, 8'h00, 8'hff, 8'h55));
    send_item(write_req(1022, 1022, 8'h10, 8'h80, 8'hf0));
    send_item(write_req(1023, 1022, 8'h7f, 8'h01, 8'hfe));
    send_item(write_req(1022, 1023, 8'h33, 8'hcc, 8'h00));
    send_item(read_req(0, 0));
    send_item(read_req(1023, 1023));
    // far past the edge: floor clamps to the last column and row
    send_item(read_req(4095, 4095));
  endtask

  // fractions at the bottom-right corner of the full store
  task automatic test_edge_fractions();
    // 1022.5 per step: an interior blend of the four corner pixels
    set_geometry(1024, 1024, StepW'(32'h03fe_8000), StepW'(32'h03fe_8000));
    send_item(read_req(1, 1));
    send_item(read_req(0, 0));
    // largest step: fraction nonzero, ceiling clamps onto the edge
    set_geometry(1024, 1024, '1, '1);
    send_item(read_req(1, 1));
    send_item(read_req(4095, 4095));
  endtask

  // zero step maps every destination pixel onto the origin
  task automatic test_zero_step();
    set_geometry(1024, 1024, '0, '0);
    send_item(read_req(4095, 4095));
    send_item(read_req(1, 2));
  endtask

  // size registers outside the legal range
  task automatic test_size_limits();
    set_geometry(0, 0, StepRst, StepRst);
    send_item(read_req(7, 9));
    set_geometry((1 << SizeW) - 1, (1 << SizeW) - 1, StepRst, StepRst);
    send_item(read_req(1023, 1023));
    send_item(read_req(0, 0));
  endtask

  // half-way blends round up
  task automatic test_half_rounding();
    set_geometry(2, 1, StepW'(1 << (FracW - 1)), StepRst);
    send_item(write_req(0, 0, 8'd0, 8'd255, 8'd100));
    send_item(write_req(1, 0, 8'd1, 8'd0, 8'd101));
    send_item(read_req(1, 0));
    send_item(read_req(2, 0));
    send_item(read_req(3, 0));
    send_item(read_req(1, 4095));
  endtask

  // random frames: fill a small source area, then mix reads with rewrites and stray writes
  task automatic test_random_frames();
    int unsigned base, done_items, raw_w, raw_h, w, h;
    base       = writes_sent + reads_sent;
    done_items = 0;
    while (done_items < RandomItems) begin
      // three idling regimes over the run
      if (done_items < RandomItems / 3)          set_idling(15, 68);
      else if (done_items < 2 * RandomItems / 3) set_idling(68, 15);
      else                                       set_idling(0, 0);
      raw_w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
      raw_h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
      set_geometry(raw_w, raw_h, pick_step(), pick_step());
      w = eff_size(SizeW'(raw_w), MaxWidthDef);
      h = eff_size(SizeW'(raw_h), MaxHeightDef);
      fill_region(w, h);
      repeat (FrameReqs) begin
        if ($urandom_range(3) != 0)
          send_item(read_req($urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(31),
                             $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(31)));
        else if ($urandom_range(1) == 0)
          send_item(write_req($urandom_range(w - 1), $urandom_range(h - 1),
                              PixW'($urandom), PixW'($urandom), PixW'($urandom)));
        else
          // anywhere inside the store, also outside the area in use: kept by the shadow store
          send_item(write_req($urandom_range(1023), $urandom_range(1023),
                              PixW'($urandom), PixW'($urandom), PixW'($urandom)));
      end
      frames_run++;
      done_items = writes_sent + reads_sent - base;
    end
  endtask

  // receiver stalls for a long stretch while reads keep coming, so the input backs up
  task automatic test_output_backpressure();
    set_idling(0, 0);
    set_geometry(5, 5, StepW'(1 << (FracW - 1)), StepW'(3 << (FracW - 2)));
    fill_region(5, 5);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (40) send_item(read_req($urandom_range(15), $urandom_range(15)));
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(15, 68);
    test_reset_geometry();
    test_edge_fractions();
    test_zero_step();
    test_size_limits();
    test_half_rounding();
    test_random_frames();
    test_output_backpressure();
    settle();
    $display("covered %0d pixel writes and %0d interpolated reads, %0d results checked",
             writes_sent, reads_sent, results_seen);
    $display("over %0d random frames and %0d register writes, %0d mismatches",
             frames_run, cfg_writes, fail_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== bilinear_image_scaler.f =====
sv/bis_pkg.sv
sv/bis_locate.sv
sv/bis_frame_mem.sv
sv/bis_blend.sv
sv/bilinear_image_scaler.sv
sim/testbench.sv
